// ===== sv/stable_priority_job_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Stable priority job queue assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_JOB_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_JOB_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPJQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SPJQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SPJQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SPJQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/spjq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority job queue package
// Shared payload types, operation and status codes, and cell control types.
// ----------------------------------------------------------------------------
package spjq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_POP       = 3'd1,
    OP_LIST_USER = 3'd2,
    OP_LIST_CAP  = 3'd3,
    OP_LIST_ALL  = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_ENTRY = 2'd1,
    STATUS_NONE  = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_e;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        job_id;
    logic [7:0]        user_id;
    logic [7:0]        cpus;
    logic [7:0]        gpus;
    logic [15:0]       mem_amount;
    logic [19:0]       run_time;
    logic signed [7:0] prio;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        out_job_id;
    logic [7:0]        out_user_id;
    logic [7:0]        out_cpus;
    logic [7:0]        out_gpus;
    logic [15:0]       out_mem;
    logic [19:0]       out_time;
    logic signed [7:0] out_prio;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic signed [7:0] prio;
    logic [7:0]        job_id;
    logic [7:0]        user_id;
    logic [7:0]        cpus;
    logic [7:0]        gpus;
    logic [15:0]       mem;
    logic [19:0]       run_time;
  } entry_t;

  typedef struct packed {
    cell_cmd_e  cmd;
    logic [2:0] op;
  } cell_ctrl_t;

  function automatic out_item_t entry_result(entry_t e, logic last);
    out_item_t r;
    r.status      = STATUS_ENTRY;
    r.out_job_id  = e.job_id;
    r.out_user_id = e.user_id;
    r.out_cpus    = e.cpus;
    r.out_gpus    = e.gpus;
    r.out_mem     = e.mem;
    r.out_time    = e.run_time;
    r.out_prio    = e.prio;
    r.last        = last;
    return r;
  endfunction

  function automatic out_item_t status_result(status_e s);
    out_item_t r;
    r        = '0;
    r.status = s;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/stable_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority job queue
// Up to DEPTH jobs held in a chain of cells, ordered by descending priority.
// ----------------------------------------------------------------------------
// The input channel carries one operation per transfer: insert, pop, list by
// user, list by capacity, list all, or clear. The output channel carries the
// results; the last result of an operation has last set.
// Insert, pop, clear and unused codes give one result, registered and
// visible the cycle after the input transfer; a new input transfer can
// follow in the next cycle if the receiver takes that result.
// A listing captures its match mask in the accept cycle, then rotates the
// ring of cells once per cycle, unless stalled, for DEPTH steps, emitting
// the head cell on each matching step; a listing with no match gives one result.
// The single output register holds a result while the receiver stalls; a
// listing then pauses on its next matching step, and no input is taken.
// Reset empties the queue and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
`include "stable_priority_job_queue_defines.svh"

module stable_priority_job_queue import spjq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic [DEPTH-1:0]  mask_q, mask_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q;
  logic              load_out;
  logic              out_free;
  logic              accept;
  logic              advance;
  logic              full;
  logic              is_list;
  cell_cmd_e         cell_cmd;
  cell_ctrl_t        ctrl;

  entry_t            entries [DEPTH];
  logic [DEPTH-1:0]  after;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  occupied;

  assign ctrl.cmd = cell_cmd;
  assign ctrl.op  = in_data_i.op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned Left  = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int unsigned Right = (i == DEPTH - 1) ? 0 : i + 1;
    logic left_after;

    assign occupied[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign left_after = 1'b1;
    end else begin : g_body
      assign left_after = after[i-1];
    end

    spjq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (in_data_i),
      .occupied_i   (occupied[i]),
      .left_after_i (left_after),
      .left_entry_i (entries[Left]),
      .right_entry_i(entries[Right]),
      .entry_o      (entries[i]),
      .after_o      (after[i]),
      .match_o      (match[i])
    );
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CntW'(DEPTH));
  assign is_list  = (in_data_i.op == OP_LIST_USER) || (in_data_i.op == OP_LIST_CAP) ||
                    (in_data_i.op == OP_LIST_ALL);
  assign advance  = (state_q == S_LIST) && (!mask_q[0] || out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && is_list && (match != '0)) begin
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        if (advance && (step_q == IdxW'(DEPTH - 1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cell_cmd   = CELL_HOLD;
    count_d    = count_q;
    mask_d     = mask_q;
    step_d     = step_q;
    load_out   = 1'b0;
    out_d      = status_result(STATUS_DONE);
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          load_out = 1'b1;
          case (in_data_i.op)
            OP_INSERT: begin
              if (full) begin
                out_d = status_result(STATUS_FULL);
              end else begin
                cell_cmd = CELL_INSERT;
                count_d  = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                out_d = status_result(STATUS_NONE);
              end else begin
                out_d    = entry_result(entries[0], 1'b1);
                cell_cmd = CELL_SHIFT;
                count_d  = count_q - 1'b1;
              end
            end
            OP_LIST_USER, OP_LIST_CAP, OP_LIST_ALL: begin
              if (match == '0) begin
                out_d = status_result(STATUS_NONE);
              end else begin
                load_out = 1'b0;
                mask_d   = match;
                step_d   = '0;
              end
            end
            OP_CLEAR: count_d = '0;
            default:  out_d = status_result(STATUS_DONE);
          endcase
        end
      end
      S_LIST: begin
        if (advance) begin
          cell_cmd = CELL_SHIFT;
          mask_d   = mask_q >> 1;
          step_d   = step_q + 1'b1;
          if (mask_q[0]) begin
            load_out = 1'b1;
            out_d    = entry_result(entries[0], mask_q[DEPTH-1:1] == '0);
          end
        end
      end
      default: cell_cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      mask_q  <= mask_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPJQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH), "Entry count exceeds depth.")
  `SPJQ_ASSERT(a_no_accept_in_list, clk_i, rst_ni, !((state_q == S_LIST) && in_ready_o), "Input ready during a listing.")
  `SPJQ_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, accept && (in_data_i.op == OP_INSERT) && !full, count_q == CntW'($past(count_q) + 1'b1), "Insert did not grow the queue.")
  `SPJQ_ASSERT_NEXT(a_list_done, clk_i, rst_ni, advance && (step_q == IdxW'(DEPTH - 1)), (mask_q == '0) && (state_q == S_IDLE), "Listing ended with matches pending.")

endmodule

// ===== sv/spjq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable priority job queue cell
// Holds one queue entry; inserts, keeps, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spjq_cell import spjq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  in_item_t   key_i,
  input  logic       occupied_i,
  input  logic       left_after_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  output entry_t     entry_o,
  output logic       after_o,
  output logic       match_o
);

  entry_t entry_q, entry_d;
  entry_t new_entry;
  logic   hit;

  always_comb begin
    new_entry.prio     = key_i.prio;
    new_entry.job_id   = key_i.job_id;
    new_entry.user_id  = key_i.user_id;
    new_entry.cpus     = key_i.cpus;
    new_entry.gpus     = key_i.gpus;
    new_entry.mem      = key_i.mem_amount;
    new_entry.run_time = key_i.run_time;
  end

  // The new entry goes behind every entry of equal or higher priority.
  assign after_o = occupied_i && (key_i.prio <= entry_q.prio);

  always_comb begin
    case (ctrl_i.op)
      OP_LIST_USER: hit = (entry_q.user_id == key_i.user_id);
      OP_LIST_CAP:  hit = (entry_q.cpus <= key_i.cpus) && (entry_q.gpus <= key_i.gpus) &&
                          (entry_q.mem <= key_i.mem_amount) &&
                          (entry_q.run_time <= key_i.run_time);
      OP_LIST_ALL:  hit = 1'b1;
      default:      hit = 1'b0;
    endcase
  end

  assign match_o = occupied_i && hit;

  always_comb begin
    case (ctrl_i.cmd)
      CELL_INSERT: begin
        if (after_o) begin
          entry_d = entry_q;
        end else if (left_after_i) begin
          entry_d = new_entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
      CELL_SHIFT: entry_d = right_entry_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== bench/tb_stable_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority job queue testbench
// Drives job operations over a valid/ready input channel and checks every
// result transfer against a local priority queue predictor. The run has
// directed cases first, then random traffic with idle bursts on both sides,
// a long output hold-off that backs up the input, and a gap-free finish.
// ----------------------------------------------------------------------------
module tb_stable_priority_job_queue;
  import spjq_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = DEPTH_DEFAULT;
  localparam logic [2:0]  OP_SPARE_A     = 3'd6;
  localparam logic [2:0]  OP_SPARE_B     = 3'd7;
  localparam logic [19:0] TIME_MAX       = 20'd999999;
  localparam int          HOLD_CYCLES    = 60;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  entry_t    job_queue[$];
  out_item_t pending_results[$];

  bit idle_en        = 1'b0;
  bit stall_en       = 1'b0;
  int mismatch_count = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int hold_requests  = 0;
  int holds_started  = 0;
  int quiet_cycles   = 0;

  stable_priority_job_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  function automatic out_item_t entry_as_result(entry_t e);
    out_item_t r;
    r             = '0;
    r.status      = STATUS_ENTRY;
    r.out_job_id  = e.job_id;
    r.out_user_id = e.user_id;
    r.out_cpus    = e.cpus;
    r.out_gpus    = e.gpus;
    r.out_mem     = e.mem;
    r.out_time    = e.run_time;
    r.out_prio    = e.prio;
    return r;
  endfunction

  function automatic void apply_job_op(in_item_t it);
    out_item_t hits[$];
    out_item_t r;
    entry_t    e;
    status_e   outcome;
    int        pos;
    bit        take;
    outcome = STATUS_DONE;
    case (it.op)
      OP_INSERT: begin
        if (job_queue.size() >= QUEUE_DEPTH) begin
          outcome = STATUS_FULL;
        end else begin
          e.prio     = it.prio;
          e.job_id   = it.job_id;
          e.user_id  = it.user_id;
          e.cpus     = it.cpus;
          e.gpus     = it.gpus;
          e.mem      = it.mem_amount;
          e.run_time = it.run_time;
          pos = 0;
          while (pos < job_queue.size() &&
                 $signed(it.prio) <= $signed(job_queue[pos].prio)) begin
            pos++;
          end
          job_queue.insert(pos, e);
        end
      end
      OP_POP: begin
        if (job_queue.size() == 0) begin
          outcome = STATUS_NONE;
        end else begin
          e = job_queue.pop_front();
          hits.push_back(entry_as_result(e));
        end
      end
      OP_LIST_USER, OP_LIST_CAP, OP_LIST_ALL: begin
        foreach (job_queue[k]) begin
          e = job_queue[k];
          case (it.op)
            OP_LIST_USER: take = (e.user_id == it.user_id);
            OP_LIST_CAP:  take = (e.cpus <= it.cpus) && (e.gpus <= it.gpus) &&
                                 (e.mem <= it.mem_amount) && (e.run_time <= it.run_time);
            default:      take = 1'b1;
          endcase
          if (take) begin
            hits.push_back(entry_as_result(e));
          end
        end
        if (hits.size() == 0) begin
          outcome = STATUS_NONE;
        end
      end
      OP_CLEAR: job_queue.delete();
      default: ;
    endcase
    if (hits.size() == 0) begin
      r        = '0;
      r.status = outcome;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (hits[k]) begin
        r      = hits[k];
        r.last = (k == hits.size() - 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic signed [7:0] pick_prio();
    case ($urandom_range(0, 4))
      0:       return 8'sh80;
      1:       return 8'sh7f;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(0, 4) - 2);
    endcase
  endfunction

  function automatic logic [19:0] limit_near(logic [19:0] at_entry, logic [19:0] top);
    case ($urandom_range(0, 2))
      0:       return top;
      1:       return at_entry;
      default: return 20'($urandom_range(0, top));
    endcase
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op         = OP_INSERT;
    it.job_id     = 8'($urandom);
    it.user_id    = 8'($urandom);
    it.cpus       = 8'($urandom);
    it.gpus       = 8'($urandom);
    it.mem_amount = 16'($urandom);
    it.run_time   = 20'($urandom_range(0, TIME_MAX));
    it.prio       = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_job_op();
    in_item_t it;
    entry_t   seen;
    int       roll;
    it   = random_fields();
    roll = $urandom_range(0, 99);
    if (job_queue.size() > 0) begin
      seen = job_queue[$urandom_range(0, job_queue.size() - 1)];
    end else begin
      seen = '0;
    end
    if (roll < 50) begin
      if ($urandom_range(0, 9) < 7) begin
        it.user_id = 8'($urandom_range(0, 3));
      end
      it.prio = pick_prio();
    end else if (roll < 62) begin
      it.op = OP_POP;
    end else if (roll < 72) begin
      it.op = OP_LIST_USER;
      if ($urandom_range(0, 9) < 6) begin
        it.user_id = seen.user_id;
      end
    end else if (roll < 82) begin
      it.op         = OP_LIST_CAP;
      it.cpus       = 8'(limit_near(seen.cpus, 20'hff));
      it.gpus       = 8'(limit_near(seen.gpus, 20'hff));
      it.mem_amount = 16'(limit_near(seen.mem, 20'hffff));
      it.run_time   = limit_near(seen.run_time, TIME_MAX);
    end else if (roll < 92) begin
      it.op = OP_LIST_ALL;
    end else if (roll < 95) begin
      it.op = OP_CLEAR;
    end else if (roll < 97) begin
      it.op = OP_SPARE_A;
    end else begin
      it.op = OP_SPARE_B;
    end
    return it;
  endfunction

  task automatic send_job_op(in_item_t it);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    apply_job_op(it);
  endtask

  always @(negedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started = hold_requests;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h",
                 $time, out_data.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("out_job_id", want.out_job_id, out_data.out_job_id);
        check_field("out_user_id", want.out_user_id, out_data.out_user_id);
        check_field("out_cpus", want.out_cpus, out_data.out_cpus);
        check_field("out_gpus", want.out_gpus, out_data.out_gpus);
        check_field("out_mem", want.out_mem, out_data.out_mem);
        check_field("out_time", want.out_time, out_data.out_time);
        check_field("out_prio", want.out_prio, out_data.out_prio);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_empty_queue();
    logic [2:0] ops[5];
    in_item_t   it;
    ops = '{OP_POP, OP_LIST_ALL, OP_LIST_USER, OP_SPARE_A, OP_SPARE_B};
    foreach (ops[k]) begin
      it    = random_fields();
      it.op = ops[k];
      send_job_op(it);
    end
  endtask

  task automatic test_ordering_and_extremes();
    in_item_t it;
    send_job_op('{OP_INSERT, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, TIME_MAX, 8'sh7f});
    send_job_op('{OP_INSERT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 20'd0, 8'sh80});
    send_job_op('{OP_INSERT, 8'h01, 8'h01, 8'h10, 8'h02, 16'h0400, 20'd1500, 8'sh00});
    send_job_op('{OP_INSERT, 8'h02, 8'h01, 8'h20, 8'h01, 16'h0200, 20'd900, 8'sh00});
    it         = random_fields();
    it.op      = OP_LIST_USER;
    it.user_id = 8'd1;
    send_job_op(it);
    it            = random_fields();
    it.op         = OP_LIST_CAP;
    it.cpus       = '0;
    it.gpus       = '0;
    it.mem_amount = '0;
    it.run_time   = '0;
    send_job_op(it);
    it.op = OP_POP;
    send_job_op(it);
  endtask

  task automatic test_fill_to_full();
    in_item_t it;
    while (job_queue.size() < QUEUE_DEPTH) begin
      it      = random_fields();
      it.prio = pick_prio();
      send_job_op(it);
    end
    it = random_fields();
    send_job_op(it);
    it.op = OP_LIST_ALL;
    send_job_op(it);
    it.op = OP_CLEAR;
    send_job_op(it);
  endtask

  task automatic test_random_mix(int count);
    idle_en  = 1'b1;
    stall_en = 1'b1;
    repeat (count) send_job_op(random_job_op());
  endtask

  task automatic test_output_backpressure();
    idle_en = 1'b0;
    hold_requests++;
    repeat (10) send_job_op(random_job_op());
  endtask

  task automatic test_back_to_back(int count);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    repeat (count) send_job_op(random_job_op());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_queue();
    test_ordering_and_extremes();
    test_fill_to_full();
    test_random_mix(42);
    test_output_backpressure();
    test_random_mix(20);
    test_back_to_back(30);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
